[hdl/swca_pkg.sv]
// ----------------------------------------------------------------------------
// swca_pkg
// shared widths, register codes and the ring term bundle for the spiral
// wipe cell alpha pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swca_pkg;

  localparam int COORD_WIDTH_DEF = 8;
  localparam int SIZE_W          = 8;
  localparam int POS_W           = 9;
  localparam int TERM_W          = 16;
  localparam int RATIO_W         = 17;
  localparam int ALPHA_W         = 17;
  localparam int ALPHA_FRAC      = 16;
  localparam int GRAY_W          = 8;
  localparam int ORDER_W         = 15;
  localparam int CFG_IDX_W       = 2;
  localparam int PIPE_DEPTH      = 6;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE        = ALPHA_W'(1) << ALPHA_FRAC;
  localparam logic [SIZE_W-1:0]  GRID_WIDTH_RST   = SIZE_W'(8);
  localparam logic [SIZE_W-1:0]  GRID_HEIGHT_RST  = SIZE_W'(5);
  localparam logic [RATIO_W-1:0] FADE_RATIO_RST   = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_FADE_RATIO  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              oog;
    logic [TERM_W-1:0] outer_k;
    logic [TERM_W-1:0] fold_k;
    logic [POS_W-1:0]  pos;
    logic [TERM_W-1:0] outer_l;
    logic [TERM_W-1:0] fold_l;
    logic [POS_W-1:0]  count_l;
  } ring_terms_t;

endpackage

[hdl/swca_ring.sv]
// ----------------------------------------------------------------------------
// swca_ring
// ring geometry: grid check, ring index, position on the ring and the
// outer ring counts for the cell and for the innermost ring
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swca_ring import swca_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [SIZE_W-1:0]      grid_w,
  input  logic [SIZE_W-1:0]      grid_h,
  input  logic [COORD_WIDTH-1:0] cell_x,
  input  logic [COORD_WIDTH-1:0] cell_y,
  output ring_terms_t            terms
);

  localparam int CMP_W = (COORD_WIDTH > SIZE_W) ? COORD_WIDTH : SIZE_W;

  function automatic logic [SIZE_W-1:0] min_size(input logic [SIZE_W-1:0] a,
                                                 input logic [SIZE_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [POS_W-1:0] ring_pos(input logic [SIZE_W-1:0] cx,
                                                input logic [SIZE_W-1:0] cy,
                                                input logic [SIZE_W-1:0] lw,
                                                input logic [SIZE_W-1:0] lh);
    logic [POS_W-1:0] p;
    if (lw == SIZE_W'(1)) begin
      p = (cy < (lh >> 1)) ? POS_W'(cy) : POS_W'(lh - SIZE_W'(1) - cy);
    end else if (lh == SIZE_W'(1)) begin
      p = (cx < (lw >> 1)) ? POS_W'(cx) : POS_W'(lw - SIZE_W'(1) - cx);
    end else if (cy == '0) begin
      p = POS_W'(cx);
    end else if (cy == lh - SIZE_W'(1)) begin
      p = POS_W'(lw - SIZE_W'(1) - cx);
    end else if (cx == '0) begin
      p = POS_W'(lw) + POS_W'(lh) - POS_W'(2) - POS_W'(cy);
    end else begin
      p = POS_W'(lw) + POS_W'(cy) - POS_W'(1);
    end
    return p;
  endfunction

  function automatic logic [POS_W-1:0] ring_count(input logic [SIZE_W-1:0] lw,
                                                  input logic [SIZE_W-1:0] lh);
    logic [POS_W-1:0] c;
    if (lw == SIZE_W'(1)) begin
      c = (POS_W'(lh) + POS_W'(1)) >> 1;
    end else if (lh == SIZE_W'(1)) begin
      c = (POS_W'(lw) + POS_W'(1)) >> 1;
    end else begin
      c = POS_W'(lw) + POS_W'(lh) - POS_W'(2);
    end
    return c;
  endfunction

  // stage one: grid check and ring index
  logic              oog_in;
  logic [SIZE_W-1:0] x_in;
  logic [SIZE_W-1:0] y_in;
  logic [SIZE_W-1:0] k_in;
  logic [SIZE_W-1:0] m_in;

  logic              st1_oog;
  logic [SIZE_W-1:0] st1_x;
  logic [SIZE_W-1:0] st1_y;
  logic [SIZE_W-1:0] st1_k;
  logic [SIZE_W-1:0] st1_l;

  always_comb begin
    oog_in = (CMP_W'(cell_x) >= CMP_W'(grid_w)) || (CMP_W'(cell_y) >= CMP_W'(grid_h));
    x_in   = SIZE_W'(cell_x);
    y_in   = SIZE_W'(cell_y);
    k_in   = min_size(min_size(x_in, grid_w - SIZE_W'(1) - x_in),
                      min_size(y_in, grid_h - SIZE_W'(1) - y_in));
    m_in   = min_size(grid_w, grid_h);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_oog <= oog_in;
      st1_x   <= x_in;
      st1_y   <= y_in;
      st1_k   <= k_in;
      st1_l   <= (m_in - SIZE_W'(1)) >> 1;
    end
  end

  // stage two: ring sizes, position and outer ring counts
  logic [POS_W-1:0]  span;
  logic [SIZE_W-1:0] lw_k;
  logic [SIZE_W-1:0] lh_k;
  logic [SIZE_W-1:0] lw_l;
  logic [SIZE_W-1:0] lh_l;
  ring_terms_t       terms_next;

  always_comb begin
    span = POS_W'(grid_w) + POS_W'(grid_h) - POS_W'(2);
    lw_k = grid_w - (st1_k << 1);
    lh_k = grid_h - (st1_k << 1);
    lw_l = grid_w - (st1_l << 1);
    lh_l = grid_h - (st1_l << 1);
    terms_next.oog     = st1_oog;
    terms_next.outer_k = TERM_W'(st1_k) * TERM_W'(span);
    terms_next.fold_k  = (TERM_W'(st1_k) * TERM_W'(st1_k - SIZE_W'(1))) << 1;
    terms_next.pos     = ring_pos(st1_x - st1_k, st1_y - st1_k, lw_k, lh_k);
    terms_next.outer_l = TERM_W'(st1_l) * TERM_W'(span);
    terms_next.fold_l  = (TERM_W'(st1_l) * TERM_W'(st1_l - SIZE_W'(1))) << 1;
    terms_next.count_l = ring_count(lw_l, lh_l);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terms <= terms_next;
    end
  end

endmodule

[hdl/swca_alpha.sv]
// ----------------------------------------------------------------------------
// swca_alpha
// order and total count, fade product, clamp to alpha and gray scaling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swca_alpha import swca_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [RATIO_W-1:0] fade_ratio,
  input  ring_terms_t        terms,
  output logic [ALPHA_W-1:0] alpha,
  output logic [GRAY_W-1:0]  gray_level,
  output logic [ORDER_W-1:0] fade_order,
  output logic               out_of_grid
);

  localparam int PROD_W  = RATIO_W + TERM_W;
  localparam int SCALE_W = ALPHA_W + GRAY_W;

  logic              st3_oog;
  logic [TERM_W-1:0] st3_order;
  logic [TERM_W-1:0] st3_total;

  logic              st4_oog;
  logic [TERM_W-1:0] st4_order;
  logic [PROD_W-1:0] st4_lead;
  logic [PROD_W-1:0] st4_drain;

  logic               st5_oog;
  logic [TERM_W-1:0]  st5_order;
  logic [ALPHA_W-1:0] st5_alpha;

  logic [PROD_W-1:0]  diff;
  logic [ALPHA_W-1:0] alpha_next;
  logic [SCALE_W-1:0] scaled;

  always_comb begin
    diff = st4_lead - st4_drain;
    if (st4_lead < st4_drain) begin
      alpha_next = '0;
    end else if (diff > PROD_W'(ALPHA_ONE)) begin
      alpha_next = ALPHA_ONE;
    end else begin
      alpha_next = ALPHA_W'(diff);
    end
    // alpha * 255 as a shift and subtract
    scaled = (SCALE_W'(st5_alpha) << GRAY_W) - SCALE_W'(st5_alpha);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st3_oog   <= terms.oog;
      st3_order <= terms.outer_k - terms.fold_k + TERM_W'(terms.pos);
      st3_total <= terms.outer_l - terms.fold_l + TERM_W'(terms.count_l);

      st4_oog   <= st3_oog;
      st4_order <= st3_order;
      st4_lead  <= PROD_W'(({1'b0, st3_order} + (TERM_W+1)'(1))) << ALPHA_FRAC;
      st4_drain <= PROD_W'(fade_ratio) * PROD_W'(st3_total);

      st5_oog   <= st4_oog;
      st5_order <= st4_order;
      st5_alpha <= alpha_next;

      out_of_grid <= st5_oog;
      alpha       <= st5_oog ? '0 : st5_alpha;
      gray_level  <= st5_oog ? '0 : scaled[ALPHA_FRAC+GRAY_W-1:ALPHA_FRAC];
      fade_order  <= st5_oog ? '0 : st5_order[ORDER_W-1:0];
    end
  end

endmodule

[hdl/spiral_wipe_cell_alpha.sv]
// ----------------------------------------------------------------------------
// spiral_wipe_cell_alpha
// throughput: one cell word per cycle, the whole pipeline advances together
// and holds while the result word waits
// reset: clears the pipeline valid bits and loads grid 8 x 5, fade ratio 0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spiral_wipe_cell_alpha import swca_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [RATIO_W-1:0]     cfg_data,
  input  logic                   cell_valid,
  output logic                   cell_ready,
  input  logic [COORD_WIDTH-1:0] cell_x,
  input  logic [COORD_WIDTH-1:0] cell_y,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [ALPHA_W-1:0]     alpha,
  output logic [GRAY_W-1:0]      gray_level,
  output logic [ORDER_W-1:0]     fade_order,
  output logic                   out_of_grid
);

  localparam int EXT_W = (COORD_WIDTH > SIZE_W) ? COORD_WIDTH : SIZE_W;

  logic [SIZE_W-1:0]     grid_width;
  logic [SIZE_W-1:0]     grid_height;
  logic [RATIO_W-1:0]    fade_ratio;
  logic [PIPE_DEPTH-1:0] valid_pipe;
  logic                  advance;

  logic [EXT_W-1:0]  width_ext;
  logic [EXT_W-1:0]  height_ext;
  logic [SIZE_W-1:0] grid_w;
  logic [SIZE_W-1:0] grid_h;
  ring_terms_t       terms;

  // grid sizes seen through the coordinate width
  always_comb begin
    width_ext  = EXT_W'(grid_width);
    height_ext = EXT_W'(grid_height);
    grid_w     = SIZE_W'(width_ext[COORD_WIDTH-1:0]);
    grid_h     = SIZE_W'(height_ext[COORD_WIDTH-1:0]);
  end

  assign cfg_ready    = 1'b1;
  assign advance      = !valid_pipe[PIPE_DEPTH-1] || result_ready;
  assign cell_ready   = advance;
  assign result_valid = valid_pipe[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
      fade_ratio  <= FADE_RATIO_RST;
      valid_pipe  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_GRID_WIDTH:  grid_width  <= cfg_data[SIZE_W-1:0];
          REG_GRID_HEIGHT: grid_height <= cfg_data[SIZE_W-1:0];
          REG_FADE_RATIO:  fade_ratio  <= cfg_data;
          default: ;
        endcase
      end
      if (advance) begin
        valid_pipe <= {valid_pipe[PIPE_DEPTH-2:0], cell_valid};
      end
    end
  end

  swca_ring #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_ring (
    .clk    (clk),
    .en     (advance),
    .grid_w (grid_w),
    .grid_h (grid_h),
    .cell_x (cell_x),
    .cell_y (cell_y),
    .terms  (terms)
  );

  swca_alpha u_alpha (
    .clk         (clk),
    .en          (advance),
    .fade_ratio  (fade_ratio),
    .terms       (terms),
    .alpha       (alpha),
    .gray_level  (gray_level),
    .fade_order  (fade_order),
    .out_of_grid (out_of_grid)
  );

  a_oog_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_of_grid |-> alpha == '0 && gray_level == '0 && fade_order == '0)
    else $error("out of grid word carries non-zero fields");

  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> alpha <= ALPHA_ONE)
    else $error("alpha above one");

  a_gray_full: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((alpha == ALPHA_ONE) == (gray_level == {GRAY_W{1'b1}})))
    else $error("gray level disagrees with full alpha");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(valid_pipe))
    else $error("pipeline moved while stalled");

endmodule
